### rtl/core/assert_macros.svh
// assertion macros shared by the mouse report encoder
// no dependencies; expects clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define MRE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequence holds in the same cycle as the antecedent
`define MRE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence holds in the cycle after the antecedent
`define MRE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/mre_pkg.sv
// package for the mouse report encoder: widths, codes, characters, shared types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mre_pkg;

    // pointer coordinate width
    localparam int COORD_BITS = 12;
    // configuration register widths
    localparam int MODE_BITS  = 3;
    localparam int ENCR_BITS  = 2;
    localparam int SCRN_BITS  = 13;
    localparam int CFG_BITS   = 13;
    localparam int IDX_CFG_BITS = 2;

    // event code width (largest code is 125)
    localparam int CODE_BITS  = 7;
    // decimal and coordinate arithmetic width
    localparam int VAL_BITS   = COORD_BITS + 1;
    localparam int DEC_DIGITS = 4;
    localparam int NDIG_BITS  = 3;

    // report buffer
    localparam int RPT_MAX    = 17;
    localparam int LEN_BITS   = $clog2(RPT_MAX + 1);
    localparam int IDX_BITS   = $clog2(RPT_MAX);

    // input word layout
    localparam int IN_BITS    = 9 + 2 * COORD_BITS;
    localparam int IN_BYTES_W = ((IN_BITS + 7) / 8) * 8;

    // configuration register indexes
    localparam logic [IDX_CFG_BITS-1:0] REG_MOUSE_MODE     = 2'd0;
    localparam logic [IDX_CFG_BITS-1:0] REG_EXT_ENCODING   = 2'd1;
    localparam logic [IDX_CFG_BITS-1:0] REG_SCREEN_COLUMNS = 2'd2;
    localparam logic [IDX_CFG_BITS-1:0] REG_SCREEN_ROWS    = 2'd3;

    // reporting modes
    localparam logic [MODE_BITS-1:0] MODE_OFF    = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_X10    = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_NORMAL = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_BUTTON = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_ANY    = 3'd4;

    // reset values of the screen size
    localparam logic [SCRN_BITS-1:0] COLS_RESET = 13'd80;
    localparam logic [SCRN_BITS-1:0] ROWS_RESET = 13'd24;

    // resolved coordinate encoding
    typedef enum logic [1:0] {
        ENC_LEGACY = 2'd0,
        ENC_SGR    = 2'd1,
        ENC_URXVT  = 2'd2
    } enc_t;

    // report characters
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_UPM   = 8'h4D;
    localparam logic [7:0] CH_LOWM  = 8'h6D;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    // decoded event passed from the code stage to the report builder
    typedef struct packed {
        logic                 hit;
        logic [CODE_BITS-1:0] code;
        logic                 release_ev;
        enc_t                 enc;
    } mre_event_t;

    // report bytes, first byte at index 0
    typedef logic [RPT_MAX-1:0][7:0] rpt_t;

    // decimal digits, units at index 0
    typedef logic [DEC_DIGITS-1:0][3:0] digits_t;

endpackage

`default_nettype wire

### rtl/core/mre_bcd.sv
// binary to decimal digits for values below 8192, by reciprocal multiplication
// depends on mre_pkg
`timescale 1ns / 1ps
`default_nettype none

module mre_bcd
    import mre_pkg::*;
(
    input  wire logic [VAL_BITS-1:0]  value,
    output logic      [NDIG_BITS-1:0] ndig,
    output digits_t                   digits
);

    // exact for every 13-bit value
    localparam logic [15:0] RECIP10   = 16'd52429;  // 2^19 / 10, rounded up
    localparam logic [12:0] RECIP100  = 13'd5243;   // 2^19 / 100, rounded up
    localparam logic [13:0] RECIP1000 = 14'd8389;   // 2^23 / 1000, rounded up

    logic [28:0] p10;
    logic [25:0] p100;
    logic [26:0] p1000;
    logic [9:0]  q10;
    logic [6:0]  q100;
    logic [3:0]  q1000;
    logic [12:0] r0;
    logic [9:0]  r1;
    logic [6:0]  r2;

    // quotients by 10, 100 and 1000 side by side
    assign p10   = 29'(value) * 29'(RECIP10);
    assign p100  = 26'(value) * 26'(RECIP100);
    assign p1000 = 27'(value) * 27'(RECIP1000);
    assign q10   = p10[28:19];
    assign q100  = p100[25:19];
    assign q1000 = p1000[26:23];

    // digits from the remainders
    assign r0 = value - 13'(q10) * 13'd10;
    assign r1 = q10 - 10'(q100) * 10'd10;
    assign r2 = q100 - 7'(q1000) * 7'd10;

    assign digits[0] = r0[3:0];
    assign digits[1] = r1[3:0];
    assign digits[2] = r2[3:0];
    assign digits[3] = q1000;

    // significant digit count, at least one
    always_comb
    begin
        priority if (q1000 != 4'd0)
        begin
            ndig = 3'd4;
        end
        else if (q100 != 7'd0)
        begin
            ndig = 3'd3;
        end
        else if (q10 != 10'd0)
        begin
            ndig = 3'd2;
        end
        else
        begin
            ndig = 3'd1;
        end
    end

endmodule

`default_nettype wire

### rtl/core/mre_event_code.sv
// event filter and code builder: mode rules, screen bounds, modifier bits
// depends on mre_pkg
`timescale 1ns / 1ps
`default_nettype none

module mre_event_code
    import mre_pkg::*;
(
    input  wire logic [MODE_BITS-1:0]  mouse_mode,
    input  wire logic [ENCR_BITS-1:0]  ext_encoding,
    input  wire logic [SCRN_BITS-1:0]  screen_columns,
    input  wire logic [SCRN_BITS-1:0]  screen_rows,
    input  wire logic [3:0]            button,
    input  wire logic                  is_release,
    input  wire logic                  is_motion,
    input  wire logic                  shift_held,
    input  wire logic                  meta_held,
    input  wire logic                  control_held,
    input  wire logic [COORD_BITS-1:0] column,
    input  wire logic [COORD_BITS-1:0] row,
    output mre_event_t                 ev
);

    localparam logic [CODE_BITS-1:0] CODE_RELEASE = 7'd3;
    localparam logic [CODE_BITS-1:0] WHEEL_OFFSET = 7'd60;

    enc_t                 enc;
    logic                 mode_ok;
    logic                 on_screen;
    logic                 base_ok;
    logic [CODE_BITS-1:0] base_code;
    logic [CODE_BITS-1:0] btn_code;
    logic                 motion_bit;

    // unknown encodings fall back to legacy
    always_comb
    begin
        if (ext_encoding == ENC_SGR)
        begin
            enc = ENC_SGR;
        end
        else if (ext_encoding == ENC_URXVT)
        begin
            enc = ENC_URXVT;
        end
        else
        begin
            enc = ENC_LEGACY;
        end
    end

    assign mode_ok   = (mouse_mode >= MODE_X10) && (mouse_mode <= MODE_ANY);
    assign on_screen = ({1'b0, column} < screen_columns) && ({1'b0, row} < screen_rows);
    assign btn_code  = {3'b000, button - 4'd1};

    // per-mode filtering and base code
    always_comb
    begin
        base_ok   = 1'b0;
        base_code = '0;
        if (mouse_mode == MODE_X10)
        begin
            base_ok   = !is_release && !is_motion && (button >= 4'd1) && (button <= 4'd3);
            base_code = btn_code;
        end
        else
        begin
            priority if (mouse_mode == MODE_NORMAL && is_motion)
            begin
                base_ok = 1'b0;
            end
            else if (button == 4'd0)
            begin
                base_ok   = (mouse_mode == MODE_ANY);
                base_code = CODE_RELEASE;
            end
            else if (button < 4'd4)
            begin
                base_ok   = 1'b1;
                base_code = (is_release && enc != ENC_SGR) ? CODE_RELEASE : btn_code;
            end
            else if (!is_release && button < 4'd6)
            begin
                base_ok   = 1'b1;
                base_code = {3'b000, button} + WHEEL_OFFSET;
            end
            else
            begin
                base_ok = 1'b0;
            end
        end
    end

    // modifier and motion bits, not in x10 mode
    assign motion_bit = is_motion && (mouse_mode >= MODE_BUTTON);

    always_comb
    begin
        ev.hit        = mode_ok && on_screen && base_ok;
        ev.release_ev = is_release;
        ev.enc        = enc;
        if (mouse_mode == MODE_X10)
        begin
            ev.code = base_code;
        end
        else
        begin
            ev.code = base_code
                    | {1'b0, motion_bit, control_held, meta_held, shift_held, 2'b00};
        end
    end

endmodule

`default_nettype wire

### rtl/core/mre_report_build.sv
// report assembly: header, code and coordinates as utf-8 or decimal fields
// depends on mre_pkg, mre_bcd
`timescale 1ns / 1ps
`default_nettype none

module mre_report_build
    import mre_pkg::*;
(
    input  wire mre_event_t            ev,
    input  wire logic [COORD_BITS-1:0] column,
    input  wire logic [COORD_BITS-1:0] row,
    output rpt_t                       rpt_bytes,
    output logic      [LEN_BITS-1:0]   rpt_len
);

    localparam int NSEG = 7;

    // one piece of the report, up to four bytes
    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      len;
    } seg_t;

    logic [VAL_BITS-1:0]  code_dec;
    logic [VAL_BITS-1:0]  col_dec;
    logic [VAL_BITS-1:0]  row_dec;
    logic [NDIG_BITS-1:0] code_nd;
    logic [NDIG_BITS-1:0] col_nd;
    logic [NDIG_BITS-1:0] row_nd;
    digits_t              code_dg;
    digits_t              col_dg;
    digits_t              row_dg;
    seg_t [NSEG-1:0]      segs;

    function automatic seg_t byte_seg(input logic [7:0] ch);
        seg_t s;
        s      = '0;
        s.b[0] = ch;
        s.len  = 3'd1;
        return s;
    endfunction

    // one or two bytes, value clamped to 2047
    function automatic seg_t utf8_seg(input logic [VAL_BITS-1:0] v);
        seg_t        s;
        logic [10:0] vc;
        s  = '0;
        vc = (v > VAL_BITS'(2047)) ? 11'h7FF : v[10:0];
        if (vc < 11'd128)
        begin
            s.b[0] = {1'b0, vc[6:0]};
            s.len  = 3'd1;
        end
        else
        begin
            s.b[0] = 8'hC0 | {3'b000, vc[10:6]};
            s.b[1] = 8'h80 | {2'b00, vc[5:0]};
            s.len  = 3'd2;
        end
        return s;
    endfunction

    // decimal digits, most significant first
    function automatic seg_t dec_seg(input digits_t dg, input logic [NDIG_BITS-1:0] nd);
        seg_t       s;
        logic [2:0] k;
        s = '0;
        for (int j = 0; j < DEC_DIGITS; j++)
        begin
            k = nd - 3'd1 - 3'(j);
            if (3'(j) < nd)
            begin
                s.b[j] = CH_ZERO | {4'b0000, dg[k[1:0]]};
            end
        end
        s.len = nd;
        return s;
    endfunction

    // decimal field values
    assign code_dec = VAL_BITS'(ev.code) + ((ev.enc == ENC_URXVT) ? VAL_BITS'(32) : '0);
    assign col_dec  = VAL_BITS'(column) + VAL_BITS'(1);
    assign row_dec  = VAL_BITS'(row) + VAL_BITS'(1);

    mre_bcd u_bcd_code (
        .value  (code_dec),
        .ndig   (code_nd),
        .digits (code_dg)
    );

    mre_bcd u_bcd_col (
        .value  (col_dec),
        .ndig   (col_nd),
        .digits (col_dg)
    );

    mre_bcd u_bcd_row (
        .value  (row_dec),
        .ndig   (row_nd),
        .digits (row_dg)
    );

    // pieces of the report for the active encoding
    always_comb
    begin
        segs = '0;
        unique case (ev.enc)
            ENC_SGR:
            begin
                segs[0].b   = {8'h00, CH_LT, CH_LBRK, CH_ESC};
                segs[0].len = 3'd3;
                segs[1]     = dec_seg(code_dg, code_nd);
                segs[2]     = byte_seg(CH_SEMI);
                segs[3]     = dec_seg(col_dg, col_nd);
                segs[4]     = byte_seg(CH_SEMI);
                segs[5]     = dec_seg(row_dg, row_nd);
                segs[6]     = byte_seg(ev.release_ev ? CH_LOWM : CH_UPM);
            end
            ENC_URXVT:
            begin
                segs[0].b   = {8'h00, 8'h00, CH_LBRK, CH_ESC};
                segs[0].len = 3'd2;
                segs[1]     = dec_seg(code_dg, code_nd);
                segs[2]     = byte_seg(CH_SEMI);
                segs[3]     = dec_seg(col_dg, col_nd);
                segs[4]     = byte_seg(CH_SEMI);
                segs[5]     = dec_seg(row_dg, row_nd);
                segs[6]     = byte_seg(CH_UPM);
            end
            default:
            begin
                segs[0].b   = {8'h00, CH_UPM, CH_LBRK, CH_ESC};
                segs[0].len = 3'd3;
                segs[1]     = utf8_seg(VAL_BITS'(ev.code) + VAL_BITS'(32));
                segs[2]     = utf8_seg(VAL_BITS'(column) + VAL_BITS'(33));
                segs[3]     = utf8_seg(VAL_BITS'(row) + VAL_BITS'(33));
            end
        endcase
    end

    // pack the pieces one after another
    always_comb
    begin
        logic [LEN_BITS-1:0] pos;
        logic [LEN_BITS-1:0] p;
        rpt_bytes = '0;
        pos       = '0;
        for (int s = 0; s < NSEG; s++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                p = pos + LEN_BITS'(j);
                if (3'(j) < segs[s].len && p < LEN_BITS'(RPT_MAX))
                begin
                    rpt_bytes[p[IDX_BITS-1:0]] = segs[s].b[j];
                end
            end
            pos = pos + LEN_BITS'(segs[s].len);
        end
        rpt_len = ev.hit ? pos : '0;
    end

endmodule

`default_nettype wire

### rtl/core/mouse_report_encoder_core.sv
// top level of the mouse report encoder: config registers, input register,
// report buffer and byte output; depends on mre_pkg, mre_event_code,
// mre_report_build and assert_macros.svh
//
// usage: one mouse event word enters on s_axis; its terminal report leaves
// on m_axis one byte per word, m_tlast on the final byte. Filtered or
// off-screen events give no output words.
// an event waits in the input register until the report buffer is free,
// then its report is built into the buffer and streams out from there. A
// report of n bytes (6 to 17) goes at one byte per cycle while m_tready is
// high, paced by the single byte output port; an event that reports nothing
// never enters the buffer. The input register takes the next event while
// the current report is still streaming, and hands it over as the last
// byte is taken. A stalled m_tready holds the current byte; s_tready drops
// once the input register is also full. Reset empties both stages and
// restores the registers: mode off, legacy encoding, 80 columns, 24 rows.
// Config writes go in through cfg_we, cfg_index and cfg_data; the user must
// make them only while idle, as the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mouse_report_encoder_core
    import mre_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // configuration writes
    input  wire logic                    cfg_we,
    input  wire logic [IDX_CFG_BITS-1:0] cfg_index,
    input  wire logic [CFG_BITS-1:0]     cfg_data,
    // event words
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // s_tdata: button[3:0], is_release[4], is_motion[5], shift_held[6],
    // meta_held[7], control_held[8], column[20:9], row[32:21], zero fill
    input  wire logic [IN_BYTES_W-1:0]   s_tdata,
    // report bytes
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // m_tdata: out_byte[7:0]
    output logic      [7:0]              m_tdata,
    // m_tlast: last_byte
    output logic                         m_tlast
);

    logic [MODE_BITS-1:0] mouse_mode_reg;
    logic [ENCR_BITS-1:0] ext_encoding_reg;
    logic [SCRN_BITS-1:0] screen_columns_reg;
    logic [SCRN_BITS-1:0] screen_rows_reg;

    logic                 ir_valid_reg;
    logic [IN_BITS-1:0]   ir_data_reg;

    logic                 ob_valid_reg;
    logic                 ob_valid_next;
    rpt_t                 ob_bytes_reg;
    logic [LEN_BITS-1:0]  ob_len_reg;
    logic [IDX_BITS-1:0]  ob_idx_reg;

    mre_event_t           ev;
    rpt_t                 rpt_bytes;
    logic [LEN_BITS-1:0]  rpt_len;

    logic                 byte_take;
    logic                 ob_done;
    logic                 ir_take;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mouse_mode_reg     <= MODE_OFF;
            ext_encoding_reg   <= ENC_LEGACY;
            screen_columns_reg <= COLS_RESET;
            screen_rows_reg    <= ROWS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MOUSE_MODE:     mouse_mode_reg     <= cfg_data[MODE_BITS-1:0];
                REG_EXT_ENCODING:   ext_encoding_reg   <= cfg_data[ENCR_BITS-1:0];
                REG_SCREEN_COLUMNS: screen_columns_reg <= cfg_data[SCRN_BITS-1:0];
                REG_SCREEN_ROWS:    screen_rows_reg    <= cfg_data[SCRN_BITS-1:0];
                default:            ;
            endcase
        end
    end

    // handshakes between the stages
    assign byte_take = ob_valid_reg && m_tready;
    assign ob_done   = byte_take && m_tlast;
    assign ir_take   = ir_valid_reg && (!ob_valid_reg || ob_done);
    assign s_tready  = !ir_valid_reg || ir_take;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ir_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            ir_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            ir_data_reg <= s_tdata[IN_BITS-1:0];
        end
    end

    // event filter and code
    mre_event_code u_event_code (
        .mouse_mode     (mouse_mode_reg),
        .ext_encoding   (ext_encoding_reg),
        .screen_columns (screen_columns_reg),
        .screen_rows    (screen_rows_reg),
        .button         (ir_data_reg[3:0]),
        .is_release     (ir_data_reg[4]),
        .is_motion      (ir_data_reg[5]),
        .shift_held     (ir_data_reg[6]),
        .meta_held      (ir_data_reg[7]),
        .control_held   (ir_data_reg[8]),
        .column         (ir_data_reg[9 +: COORD_BITS]),
        .row            (ir_data_reg[9 + COORD_BITS +: COORD_BITS]),
        .ev             (ev)
    );

    // report bytes for the held event
    mre_report_build u_report_build (
        .ev        (ev),
        .column    (ir_data_reg[9 +: COORD_BITS]),
        .row       (ir_data_reg[9 + COORD_BITS +: COORD_BITS]),
        .rpt_bytes (rpt_bytes),
        .rpt_len   (rpt_len)
    );

    // report buffer control
    always_comb
    begin
        priority if (ir_take)
        begin
            ob_valid_next = (rpt_len != '0);
        end
        else if (ob_done)
        begin
            ob_valid_next = 1'b0;
        end
        else
        begin
            ob_valid_next = ob_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_valid_reg <= 1'b0;
            ob_idx_reg   <= '0;
        end
        else
        begin
            ob_valid_reg <= ob_valid_next;
            if (ir_take)
            begin
                ob_idx_reg <= '0;
            end
            else if (byte_take && !m_tlast)
            begin
                ob_idx_reg <= ob_idx_reg + IDX_BITS'(1);
            end
        end
    end

    // report buffer payload
    always_ff @(posedge clk)
    begin
        if (ir_take)
        begin
            ob_bytes_reg <= rpt_bytes;
            ob_len_reg   <= rpt_len;
        end
    end

    // byte output
    assign m_tvalid = ob_valid_reg;
    assign m_tdata  = ob_bytes_reg[ob_idx_reg];
    assign m_tlast  = (LEN_BITS'(ob_idx_reg) == ob_len_reg - LEN_BITS'(1));

    // checks
    `MRE_ASSERT_SAME(a_idx_in_len, ob_valid_reg, LEN_BITS'(ob_idx_reg) < ob_len_reg, "index past length")
    `MRE_ASSERT_SAME(a_starts_esc, m_tvalid && ob_idx_reg == '0, m_tdata == CH_ESC, "no escape")
    `MRE_ASSERT_NEXT(a_drop_after_last, ob_done && !ir_take, !m_tvalid, "valid after final byte")

endmodule

`default_nettype wire
